// File: hdl/bbd_pkg.sv
// Shared types, register indexes and colour lookup for the Bayer demosaic.
package bbd_pkg;

  localparam int MaxWidth   = 4096;
  localparam int SampleBits = 16;
  localparam int ColBits    = $clog2(MaxWidth);

  // Configuration register indexes
  localparam logic [2:0] RegFrameWidth  = 3'd0;
  localparam logic [2:0] RegFrameHeight = 3'd1;
  localparam logic [2:0] RegCfaPattern  = 3'd2;
  localparam logic [2:0] RegXPhase      = 3'd3;
  localparam logic [2:0] RegYPhase      = 3'd4;
  localparam logic [2:0] RegCfaMode     = 3'd5;
  localparam logic [2:0] RegGain        = 3'd6;

  // Colour codes
  localparam logic [1:0] ColR = 2'd0;
  localparam logic [1:0] ColG = 2'd1;
  localparam logic [1:0] ColB = 2'd2;

  // Modes
  localparam logic [1:0] ModeGrey     = 2'd0;
  localparam logic [1:0] ModeRaw      = 2'd1;
  localparam logic [1:0] ModeBilinear = 2'd2;
  localparam logic [1:0] ModeGradient = 2'd3;

  typedef struct packed {
    logic       clr;
    logic       latch;
    logic       rd;
    logic       upd;
    logic       mul;
    logic       norm;
    logic       div;
    logic [1:0] ch;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_go;
    logic out_free;
  } status_t;

  function automatic logic [1:0] colour_at(input logic [1:0] pat, input logic py,
                                           input logic px);
    logic [1:0] c;
    c = ColR;
    unique case ({pat, py, px})
      4'b0000: c = ColR;
      4'b0001: c = ColG;
      4'b0010: c = ColG;
      4'b0011: c = ColB;
      4'b0100: c = ColG;
      4'b0101: c = ColR;
      4'b0110: c = ColB;
      4'b0111: c = ColG;
      4'b1000: c = ColG;
      4'b1001: c = ColB;
      4'b1010: c = ColR;
      4'b1011: c = ColG;
      4'b1100: c = ColB;
      4'b1101: c = ColG;
      4'b1110: c = ColG;
      4'b1111: c = ColR;
      default: c = ColR;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/bbd_ctrl.sv
// Sequencer: line store clear, item intake, window update and per-channel scaling.
module bbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bbd_pkg::status_t status_i,
  output bbd_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StNrm  = 3'd5;
  localparam logic [2:0] StDiv  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.ch = ch_q;
    unique case (state_q)
      StClr: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = StRd;
        end
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        ch_d = 2'd0;
        state_d = status_i.out_go ? StMul : StIdle;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StNrm;
      end
      StNrm: begin
        cmd_o.norm = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (ch_q == 2'd2) begin
          state_d = StOut;
        end else begin
          ch_d = ch_q + 2'd1;
          state_d = StMul;
        end
      end
      StOut: begin
        // hold until the output register frees up
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      ch_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

endmodule

// File: hdl/bbd_dp.sv
// Datapath: configuration, line stores, 3x3 window, counters, scaling and output register.
module bbd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [16:0]         cfg_wdata_i,
  input  logic [15:0]         sample_i,
  input  logic                flush_i,
  input  bbd_pkg::cmd_t       cmd_i,
  output bbd_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [47:0]         out_data_o,
  output logic                out_line_end_o,
  output logic                out_frame_end_o
);

  localparam int CB = bbd_pkg::ColBits;
  localparam int SB = bbd_pkg::SampleBits;
  localparam logic [19:0] Recip3 = 20'd699051;

  // configuration
  logic [12:0] fw_q;
  logic [15:0] fh_q;
  logic [1:0]  pat_q, mode_q;
  logic        xph_q, yph_q;
  logic [16:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 13'd4096;
      fh_q   <= 16'd1;
      pat_q  <= 2'd0;
      xph_q  <= 1'b0;
      yph_q  <= 1'b0;
      mode_q <= 2'd0;
      gain_q <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bbd_pkg::RegFrameWidth:  fw_q   <= cfg_wdata_i[12:0];
        bbd_pkg::RegFrameHeight: fh_q   <= cfg_wdata_i[15:0];
        bbd_pkg::RegCfaPattern:  pat_q  <= cfg_wdata_i[1:0];
        bbd_pkg::RegXPhase:      xph_q  <= cfg_wdata_i[0];
        bbd_pkg::RegYPhase:      yph_q  <= cfg_wdata_i[0];
        bbd_pkg::RegCfaMode:     mode_q <= cfg_wdata_i[1:0];
        bbd_pkg::RegGain:        gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [12:0] w_eff;
  logic [16:0] h_eff;
  assign w_eff = (fw_q == 13'd0) ? 13'd1 :
                 (fw_q > 13'(bbd_pkg::MaxWidth)) ? 13'(bbd_pkg::MaxWidth) : fw_q;
  assign h_eff = (fh_q == 16'd0) ? 17'd1 : {1'b0, fh_q};

  // counters
  logic [CB-1:0] ic_q, oc_q;
  logic [16:0]   ir_q;
  logic [15:0]   or_q;
  logic          started_q;
  logic [CB-1:0] clr_q;

  // item and memories
  logic [SB-1:0] val_q, rd_a_q, rd_b_q;
  logic [CB-1:0] col_q;
  logic [SB-1:0] mem_a [bbd_pkg::MaxWidth];
  logic [SB-1:0] mem_b [bbd_pkg::MaxWidth];
  logic [SB-1:0] win_q [9];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      col_q <= ic_q;
      val_q <= (flush_i || ir_q >= h_eff) ? '0 : sample_i;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem_a[col_q];
      rd_b_q <= mem_b[col_q];
    end
    if (cmd_i.clr) begin
      mem_a[clr_q] <= '0;
      mem_b[clr_q] <= '0;
    end else if (cmd_i.upd) begin
      mem_a[col_q] <= val_q;
      mem_b[col_q] <= rd_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign status_o.clr_last = (clr_q == CB'(bbd_pkg::MaxWidth - 1));

  // window update and position flags
  logic started_n;
  logic fl_l_q, fl_r_q, fl_u_q, fl_d_q, px_q, py_q, le_q, fe_q;
  logic fl_r, fl_d;

  assign started_n = started_q || (ir_q >= 17'd2) || (ir_q == 17'd1 && ic_q != '0);
  assign fl_r = ({1'b0, oc_q} + 13'd1) < w_eff;
  assign fl_d = ({1'b0, or_q} + 17'd1) < h_eff;
  assign status_o.out_go = started_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      ic_q      <= '0;
      ir_q      <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.upd) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= rd_b_q;
      win_q[5] <= rd_a_q;
      win_q[8] <= val_q;
      if (({1'b0, ic_q} + 13'd1) >= w_eff) begin
        ic_q <= '0;
        ir_q <= ir_q + 17'd1;
      end else begin
        ic_q <= ic_q + 1'b1;
      end
      started_q <= started_n;
      if (started_n) begin
        if (!fl_r && !fl_d) begin
          // frame done: restart the input and output counters
          ic_q      <= '0;
          ir_q      <= '0;
          oc_q      <= '0;
          or_q      <= '0;
          started_q <= 1'b0;
        end else if (!fl_r) begin
          oc_q <= '0;
          or_q <= or_q + 16'd1;
        end else begin
          oc_q <= oc_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      fl_l_q <= (oc_q != '0);
      fl_r_q <= fl_r;
      fl_u_q <= (or_q != '0);
      fl_d_q <= fl_d;
      px_q   <= oc_q[0] ^ xph_q;
      py_q   <= or_q[0] ^ yph_q;
      le_q   <= !fl_r;
      fe_q   <= !fl_r && !fl_d;
    end
  end

  // neighbour selection for one channel
  logic [1:0]  own;
  logic [17:0] sel_sum;
  logic [2:0]  sel_n;
  logic        row_has, col_has;

  assign own = bbd_pkg::colour_at(pat_q, py_q, px_q);
  assign row_has = (bbd_pkg::colour_at(pat_q, py_q, 1'b0) == cmd_i.ch) ||
                   (bbd_pkg::colour_at(pat_q, py_q, 1'b1) == cmd_i.ch);
  assign col_has = (bbd_pkg::colour_at(pat_q, 1'b0, px_q) == cmd_i.ch) ||
                   (bbd_pkg::colour_at(pat_q, 1'b1, px_q) == cmd_i.ch);

  always_comb begin
    sel_sum = '0;
    sel_n   = '0;
    unique case (mode_q)
      bbd_pkg::ModeGrey: begin
        sel_sum = 18'(win_q[4]);
        sel_n   = 3'd1;
      end
      bbd_pkg::ModeRaw: begin
        if (own == cmd_i.ch) begin
          sel_sum = 18'(win_q[4]);
          sel_n   = 3'd1;
        end
      end
      bbd_pkg::ModeBilinear: begin
        if (own == cmd_i.ch) begin
          sel_sum = 18'(win_q[4]);
          sel_n   = 3'd1;
        end else if (cmd_i.ch == bbd_pkg::ColG || row_has) begin
          if (fl_l_q) begin sel_sum = sel_sum + 18'(win_q[3]); sel_n = sel_n + 3'd1; end
          if (fl_r_q) begin sel_sum = sel_sum + 18'(win_q[5]); sel_n = sel_n + 3'd1; end
          if (cmd_i.ch == bbd_pkg::ColG) begin
            if (fl_u_q) begin sel_sum = sel_sum + 18'(win_q[1]); sel_n = sel_n + 3'd1; end
            if (fl_d_q) begin sel_sum = sel_sum + 18'(win_q[7]); sel_n = sel_n + 3'd1; end
          end
        end else if (col_has) begin
          if (fl_u_q) begin sel_sum = sel_sum + 18'(win_q[1]); sel_n = sel_n + 3'd1; end
          if (fl_d_q) begin sel_sum = sel_sum + 18'(win_q[7]); sel_n = sel_n + 3'd1; end
        end else begin
          if (fl_l_q && fl_u_q) begin sel_sum = sel_sum + 18'(win_q[0]); sel_n = sel_n + 3'd1; end
          if (fl_l_q && fl_d_q) begin sel_sum = sel_sum + 18'(win_q[6]); sel_n = sel_n + 3'd1; end
          if (fl_r_q && fl_d_q) begin sel_sum = sel_sum + 18'(win_q[8]); sel_n = sel_n + 3'd1; end
          if (fl_r_q && fl_u_q) begin sel_sum = sel_sum + 18'(win_q[2]); sel_n = sel_n + 3'd1; end
        end
      end
      default: ;
    endcase
  end

  // scale: floor(floor((2*sum*gain + n*65536) / 2^17) / n), saturated
  logic [34:0] prod_q;
  logic [2:0]  n_q;
  logic [19:0] q_q;
  logic [36:0] p_full;
  logic [39:0] q3;
  logic [19:0] quot;
  logic [15:0] res_q [3];

  assign p_full = {1'b0, prod_q, 1'b0} + {18'd0, n_q, 16'd0};
  assign q3     = q_q * Recip3;

  always_comb begin
    case (n_q)
      3'd1:    quot = q_q;
      3'd2:    quot = {1'b0, q_q[19:1]};
      3'd3:    quot = q3[40-1:21] == '0 ? 20'd0 : {1'b0, q3[39:21]};
      3'd4:    quot = {2'b0, q_q[19:2]};
      default: quot = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= sel_sum * gain_q;
      n_q    <= sel_n;
    end
    if (cmd_i.norm) q_q <= p_full[36:17];
    if (cmd_i.div) res_q[cmd_i.ch] <= (quot > 20'd65535) ? 16'hFFFF : quot[15:0];
  end

  // output register
  logic out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_o      <= {res_q[2], res_q[1], res_q[0]};
      out_line_end_o  <= le_q;
      out_frame_end_o <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/bayer_bilinear_demosaic_top.sv
// Bilinear Bayer demosaic: top level with stream ports and configuration port.
// Each item passes intake, line store read and window update; when it yields a pixel,
// the three channels then pass the shared scaling unit (multiply, normalize, divide)
// one after another, then the output register loads once it is free.
// First pixel of a frame leaves with input item frame_width + 2, counting from one;
// then one pixel per item. Reset is asynchronous, active low; afterwards both line
// stores are cleared, during which no item is accepted (configuration writes still are).
module bayer_bilinear_demosaic_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] red_out, [31:16] green_out, [47:32] blue_out
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] frame_end
);

  bbd_pkg::cmd_t    cmd;
  bbd_pkg::status_t status;

  bbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_i        (s_axis_tdata),
    .flush_i         (s_axis_tuser),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_line_end_o  (m_axis_tlast),
    .out_frame_end_o (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // one item at a time: intake closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while previous one still in work");

  // a frame end is always a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without line end");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the Bayer demosaic: directed table, random frames, predictor-based checking.
module tb_top;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        le;
    logic        fe;
  } pixel_t;

  typedef struct {
    int          setup;
    logic [15:0] smp;
    logic        fl;
    bit          typed;
    pixel_t      px;
  } row_t;

  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  bayer_bilinear_demosaic_top DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [12:0] cw;
  logic [15:0] chh;
  logic [1:0]  cpat;
  logic        xph, yph;
  logic [1:0]  cmode;
  logic [16:0] cgain;
  logic [15:0] la [bbd_pkg::MaxWidth];
  logic [15:0] lb [bbd_pkg::MaxWidth];
  logic [15:0] wnd [9];
  int unsigned in_col, in_row, out_col, out_row;
  bit          started;
  logic [1:0]  cfa_lut [4][4] = '{
    '{bbd_pkg::ColR, bbd_pkg::ColG, bbd_pkg::ColG, bbd_pkg::ColB},
    '{bbd_pkg::ColG, bbd_pkg::ColR, bbd_pkg::ColB, bbd_pkg::ColG},
    '{bbd_pkg::ColG, bbd_pkg::ColB, bbd_pkg::ColR, bbd_pkg::ColG},
    '{bbd_pkg::ColB, bbd_pkg::ColG, bbd_pkg::ColG, bbd_pkg::ColR}};

  pixel_t pixel_q[$];
  row_t   rows[$];
  int     fails = 0;
  int     sent = 0;
  int     got_cnt = 0;
  int     idle_cnt = 0;
  bit     no_gaps = 0;
  bit     pressed = 0;
  int     stall_left = 0;

  function automatic logic [15:0] scale_avg(logic [63:0] sum, logic [63:0] n);
    logic [63:0] q;
    if (n == 0) return 16'd0;
    q = (sum * cgain * 2 + n * 65536) / (n * 131072);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [1:0] colour(int unsigned x, int unsigned y);
    return cfa_lut[cpat][{y[0], x[0]}];
  endfunction

  function automatic logic [15:0] avg_rb(logic [1:0] tgt, int unsigned x, int unsigned y,
                                         bit l, bit r, bit u, bit d);
    logic [63:0] s, n;
    s = 0;
    n = 0;
    if (colour(0, y) == tgt || colour(1, y) == tgt) begin
      if (l) begin s += wnd[3]; n++; end
      if (r) begin s += wnd[5]; n++; end
    end else if (colour(x, 0) == tgt || colour(x, 1) == tgt) begin
      if (u) begin s += wnd[1]; n++; end
      if (d) begin s += wnd[7]; n++; end
    end else begin
      if (l && u) begin s += wnd[0]; n++; end
      if (l && d) begin s += wnd[6]; n++; end
      if (r && d) begin s += wnd[8]; n++; end
      if (r && u) begin s += wnd[2]; n++; end
    end
    return scale_avg(s, n);
  endfunction

  function automatic logic [15:0] avg_g(bit l, bit r, bit u, bit d);
    logic [63:0] s, n;
    s = 0;
    n = 0;
    if (l) begin s += wnd[3]; n++; end
    if (r) begin s += wnd[5]; n++; end
    if (u) begin s += wnd[1]; n++; end
    if (d) begin s += wnd[7]; n++; end
    return scale_avg(s, n);
  endfunction

  task automatic demosaic_predict(input logic [15:0] smp, input logic fl,
                                  output bit got, output pixel_t p);
    int unsigned w, h, ic, ir, x, y;
    logic [15:0] v, a1, a2, ownv;
    logic [1:0]  own;
    bit l, r, u, d;
    w = (cw == 0) ? 1 : ((cw > bbd_pkg::MaxWidth) ? bbd_pkg::MaxWidth : cw);
    h = (chh == 0) ? 1 : chh;
    ic = in_col;
    ir = in_row;
    v = (fl || ir >= h) ? 16'd0 : smp;
    a1 = la[ic];
    a2 = lb[ic];
    lb[ic] = a1;
    la[ic] = v;
    for (int k = 0; k < 3; k++) begin
      wnd[k*3] = wnd[k*3+1];
      wnd[k*3+1] = wnd[k*3+2];
    end
    wnd[2] = a2;
    wnd[5] = a1;
    wnd[8] = v;
    if (ir >= 2 || (ir == 1 && ic >= 1)) started = 1;
    if (ic + 1 >= w) begin
      in_col = 0;
      in_row = ir + 1;
    end else begin
      in_col = ic + 1;
    end
    got = started;
    p = '{default: '0};
    if (!got) return;
    l = out_col > 0;
    r = out_col + 1 < w;
    u = out_row > 0;
    d = out_row + 1 < h;
    x = out_col + xph;
    y = out_row + yph;
    own = colour(x, y);
    ownv = scale_avg(wnd[4], 1);
    case (cmode)
      bbd_pkg::ModeGrey: begin
        p.red = ownv;
        p.green = ownv;
        p.blue = ownv;
      end
      bbd_pkg::ModeRaw: begin
        if (own == bbd_pkg::ColR) p.red = ownv;
        else if (own == bbd_pkg::ColG) p.green = ownv;
        else p.blue = ownv;
      end
      bbd_pkg::ModeBilinear: begin
        if (own == bbd_pkg::ColR) begin
          p.red = ownv;
          p.green = avg_g(l, r, u, d);
          p.blue = avg_rb(bbd_pkg::ColB, x, y, l, r, u, d);
        end else if (own == bbd_pkg::ColG) begin
          p.red = avg_rb(bbd_pkg::ColR, x, y, l, r, u, d);
          p.green = ownv;
          p.blue = avg_rb(bbd_pkg::ColB, x, y, l, r, u, d);
        end else begin
          p.red = avg_rb(bbd_pkg::ColR, x, y, l, r, u, d);
          p.green = avg_g(l, r, u, d);
          p.blue = ownv;
        end
      end
      default: ;
    endcase
    p.le = !r;
    p.fe = !r && !d;
    if (p.fe) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      started = 0;
    end else if (p.le) begin
      out_col = 0;
      out_row = out_row + 1;
    end else begin
      out_col = out_col + 1;
    end
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_gaps || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bbd_pkg::RegFrameWidth:  cw = val[12:0];
      bbd_pkg::RegFrameHeight: chh = val[15:0];
      bbd_pkg::RegCfaPattern:  cpat = val[1:0];
      bbd_pkg::RegXPhase:      xph = val[0];
      bbd_pkg::RegYPhase:      yph = val[0];
      bbd_pkg::RegCfaMode:     cmode = val[1:0];
      bbd_pkg::RegGain:        cgain = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int w, h, pat, xp, yp, mode, gain);
    // drop the offer so no stale item is taken while idle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    // drain, then let the last item without a pixel finish
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_write(bbd_pkg::RegFrameWidth, 17'(w));
    cfg_write(bbd_pkg::RegFrameHeight, 17'(h));
    cfg_write(bbd_pkg::RegCfaPattern, 17'(pat));
    cfg_write(bbd_pkg::RegXPhase, 17'(xp));
    cfg_write(bbd_pkg::RegYPhase, 17'(yp));
    cfg_write(bbd_pkg::RegCfaMode, 17'(mode));
    cfg_write(bbd_pkg::RegGain, 17'(gain));
  endtask

  task automatic push_sample(input logic [15:0] smp, input logic fl, input bit typed,
                             input pixel_t tp);
    bit     got;
    pixel_t p;
    int     g;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tuser <= fl;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    demosaic_predict(smp, fl, got, p);
    if (typed) pixel_q.insert(pixel_q.size(), tp);
    else if (got) pixel_q.insert(pixel_q.size(), p);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic add_row(input int setup, input logic [15:0] smp, input logic fl,
                         input bit typed, input logic [15:0] r, g, b, input logic le, fe);
    row_t rw;
    rw.setup = setup;
    rw.smp = smp;
    rw.fl = fl;
    rw.typed = typed;
    rw.px = '{r, g, b, le, fe};
    rows.insert(rows.size(), rw);
  endtask

  task automatic random_frame(input int fidx);
    int w, h, wn, gsel, gain, mode;
    pixel_t dummy;
    dummy = '{default: '0};
    w = $urandom_range(0, 99);
    w = (w < 50) ? $urandom_range(1, 4) : ((w < 85) ? $urandom_range(5, 16)
                                                     : $urandom_range(17, 40));
    h = $urandom_range(1, 6);
    gsel = $urandom_range(0, 5);
    gain = (gsel == 0) ? 0 : (gsel == 1) ? 65536 : (gsel == 2) ? 131071
         : (gsel == 3) ? 32768 : $urandom_range(0, 65536);
    mode = ($urandom_range(0, 1) == 1) ? bbd_pkg::ModeBilinear : $urandom_range(0, 3);
    if (fidx == 3) begin
      w = 0;
      h = 0;
    end else if (fidx == 6) begin
      w = 48;
      h = 2;
    end else if (fidx == 9) begin
      w = 33;
      h = 1;
      mode = bbd_pkg::ModeBilinear;
    end
    apply_setting(w, h, $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                  mode, gain);
    wn = (w == 0) ? 1 : ((w > bbd_pkg::MaxWidth) ? bbd_pkg::MaxWidth : w);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < wn * ((h == 0) ? 1 : h); i++) begin
      case ($urandom_range(0, 9))
        0: push_sample(16'h0000, 1'b0, 0, dummy);
        1: push_sample(16'hFFFF, 1'b0, 0, dummy);
        2: push_sample(16'($urandom), ($urandom_range(0, 9) == 0), 0, dummy);
        default: push_sample(16'($urandom), 1'b0, 0, dummy);
      endcase
    end
    // pad out the window
    for (int i = 0; i <= wn; i++) push_sample(16'($urandom), 1'($urandom_range(0, 1)), 0, dummy);
  endtask

  // receiver readiness, with one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (!pressed && got_cnt >= 60) begin
        pressed = 1;
        stall_left = 400;
      end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 9) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchLimit) begin
        $display("tb_top failed");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_cnt++;
        if (pixel_q.size() == 0) begin
          $error("pixel with no expectation: %h", m_axis_tdata);
          fails++;
        end else begin
          e = pixel_q.pop_front();
          if (m_axis_tdata[15:0] !== e.red) begin
            $error("red_out expected %h got %h", e.red, m_axis_tdata[15:0]);
            fails++;
          end
          if (m_axis_tdata[31:16] !== e.green) begin
            $error("green_out expected %h got %h", e.green, m_axis_tdata[31:16]);
            fails++;
          end
          if (m_axis_tdata[47:32] !== e.blue) begin
            $error("blue_out expected %h got %h", e.blue, m_axis_tdata[47:32]);
            fails++;
          end
          if (m_axis_tlast !== e.le) begin
            $error("line_end expected %b got %b", e.le, m_axis_tlast);
            fails++;
          end
          if (m_axis_tuser !== e.fe) begin
            $error("frame_end expected %b got %b", e.fe, m_axis_tuser);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    int   cur;
    int   fidx;
    row_t rw;
    cw = 13'd4096;
    chh = 16'd1;
    cpat = 2'd0;
    xph = 1'b0;
    yph = 1'b0;
    cmode = bbd_pkg::ModeGrey;
    cgain = 17'd65536;
    for (int i = 0; i < bbd_pkg::MaxWidth; i++) begin
      la[i] = '0;
      lb[i] = '0;
    end
    for (int i = 0; i < 9; i++) wnd[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    started = 0;

    // grey copy, 2x2: pixels come back as they went in
    add_row(1, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'h5555, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'hAAAA, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0);
    add_row(1, 16'h1234, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
    add_row(1, 16'h4321, 1, 1, 16'h5555, 16'h5555, 16'h5555, 0, 0);
    add_row(1, 16'hFFFF, 1, 1, 16'hAAAA, 16'hAAAA, 16'hAAAA, 1, 1);
    // raw Bayer, RGGB: only the own colour survives
    add_row(2, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 16'h0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 16'h8000, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 16'h7FFF, 0, 1, 16'hFFFF, 0, 0, 0, 0);
    add_row(2, 16'h0000, 1, 1, 0, 16'h0001, 0, 1, 0);
    add_row(2, 16'h0000, 0, 1, 0, 16'h8000, 0, 0, 0);
    add_row(2, 16'h0000, 1, 1, 0, 0, 16'h7FFF, 1, 1);
    // gradient, single pixel frame: all zero
    add_row(3, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(3, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(3, 16'hFFFF, 0, 1, 0, 0, 0, 1, 1);
    // bilinear, BGGR, 2x2
    add_row(4, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'h0001, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'h0000, 1, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'h0000, 1, 0, 0, 0, 0, 0, 0);
    add_row(4, 16'h0000, 1, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur = 0;
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.setup != cur) begin
        cur = rw.setup;
        case (cur)
          1: apply_setting(2, 2, 0, 0, 0, bbd_pkg::ModeGrey, 65536);
          2: apply_setting(2, 2, 0, 0, 0, bbd_pkg::ModeRaw, 65536);
          3: apply_setting(1, 1, 3, 1, 1, bbd_pkg::ModeGradient, 131071);
          default: apply_setting(2, 2, 3, 0, 0, bbd_pkg::ModeBilinear, 65536);
        endcase
      end
      push_sample(rw.smp, rw.fl, rw.typed, rw.px);
    end

    fidx = 0;
    while (sent < 800 || fidx < 12) begin
      random_frame(fidx);
      fidx++;
    end
    no_gaps = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    // largest height is written once while idle
    cfg_write(bbd_pkg::RegFrameHeight, 17'd65535);
    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// File: bayer_bilinear_demosaic_top.f
hdl/bbd_pkg.sv
hdl/bbd_ctrl.sv
hdl/bbd_dp.sv
hdl/bayer_bilinear_demosaic_top.sv
tb/sv/tb_top.sv
